/* rtl/plbu_pkg.sv */
// Package for the price level book update block.
// Holds the field widths, side codes, item and result types and the control
// structs passed to the book rows and their cells. No dependencies.
package plbu_pkg;

	localparam int PRICE_BITS = 32;
	localparam int VOLUME_BITS = 48;
	localparam int LEVEL_CNT_BITS = 7;

	localparam logic SIDE_BID = 1'b0;
	localparam logic SIDE_ASK = 1'b1;

	typedef logic [PRICE_BITS-1:0] price_t;
	typedef logic [VOLUME_BITS-1:0] volume_t;
	typedef logic [LEVEL_CNT_BITS-1:0] level_cnt_t;

	typedef struct packed {
		price_t price;
		volume_t volume;
	} level_t;

	typedef struct packed {
		logic level_present;
		logic side;
		logic snapshot;
		logic first_of_message;
		logic last_of_message;
		price_t price;
		volume_t volume;
	} item_t;

	typedef struct packed {
		logic book_valid;
		price_t best_bid_price;
		volume_t best_bid_volume;
		price_t best_ask_price;
		volume_t best_ask_volume;
		level_cnt_t bid_levels;
		level_cnt_t ask_levels;
		logic overflow;
	} result_t;

	// Command from the sequencer to one side of the book.
	typedef struct packed {
		logic cmp;
		logic clr;
		logic upd;
		logic pop;
		level_t lvl;
	} row_cmd_t;

	// Decoded operation broadcast to every cell of one side.
	typedef struct packed {
		logic cmp;
		logic ins;
		logic del;
		logic wr;
		logic pop;
		level_t lvl;
	} cell_ctl_t;

endpackage

/* rtl/plbu_cell.sv */
// One cell of a sorted book side: holds one price level and its compare flags.
// Depends on plbu_pkg; instantiated as a chain by plbu_row.
module plbu_cell #(
	parameter bit DESC = 1'b1
) (
	input  logic               clk,
	input  plbu_pkg::cell_ctl_t ctl,
	input  logic               valid,
	input  logic               left_before,
	input  plbu_pkg::level_t   left_lvl,
	input  plbu_pkg::level_t   right_lvl,
	output plbu_pkg::level_t   lvl,
	output logic               ahead,
	output logic               eq
);

	plbu_pkg::level_t lvl_q;
	logic better_q;
	logic eq_q;
	logic better_c;

	always_comb begin
		if (DESC) begin
			better_c = lvl_q.price > ctl.lvl.price;
		end else begin
			better_c = lvl_q.price < ctl.lvl.price;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			better_q <= better_c;
			eq_q <= lvl_q.price == ctl.lvl.price;
		end
		if (ctl.pop) begin
			lvl_q <= right_lvl;
		end else if (ctl.del && valid && !better_q) begin
			lvl_q <= right_lvl;
		end else if (ctl.wr && valid && eq_q) begin
			lvl_q.volume <= ctl.lvl.volume;
		end else if (ctl.ins && !(valid && better_q)) begin
			lvl_q <= left_before ? ctl.lvl : left_lvl;
		end
	end

	assign lvl = lvl_q;
	assign ahead = valid && better_q;
	assign eq = valid && eq_q;

endmodule

/* rtl/plbu_row.sv */
// One side of the book: a chain of plbu_cell kept sorted, plus its level count.
// Decodes delete, overwrite and insert from the cells' compare flags.
// Depends on plbu_pkg and plbu_cell.
module plbu_row #(
	parameter int LEVELS = 64,
	parameter bit DESC = 1'b1,
	parameter int CW = $clog2(LEVELS + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  plbu_pkg::row_cmd_t  cmd,
	output logic [CW-1:0]       count,
	output plbu_pkg::level_t    head,
	output logic                overflow
);

	logic [CW-1:0] count_q;
	plbu_pkg::cell_ctl_t ctl;
	plbu_pkg::level_t lvl [LEVELS];
	logic [LEVELS-1:0] before_v;
	logic [LEVELS-1:0] eq_v;
	logic found;
	logic full;
	logic vol_zero;

	assign found = |eq_v;
	assign full = count_q == CW'(LEVELS);
	assign vol_zero = cmd.lvl.volume == '0;

	always_comb begin
		ctl.cmp = cmd.cmp;
		ctl.pop = cmd.pop;
		ctl.del = cmd.upd && vol_zero && found;
		ctl.wr = cmd.upd && !vol_zero && found;
		ctl.ins = cmd.upd && !vol_zero && !found && !full;
		ctl.lvl = cmd.lvl;
	end

	assign overflow = cmd.upd && !vol_zero && !found && full;

	for (genvar i = 0; i < LEVELS; i++) begin : g_cell
		plbu_cell #(
			.DESC(DESC)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.valid      (CW'(i) < count_q),
			.left_before((i == 0) ? 1'b1 : before_v[(i == 0) ? 0 : i - 1]),
			.left_lvl   ((i == 0) ? cmd.lvl : lvl[(i == 0) ? 0 : i - 1]),
			.right_lvl  (lvl[(i == LEVELS - 1) ? i : i + 1]),
			.lvl        (lvl[i]),
			.ahead      (before_v[i]),
			.eq         (eq_v[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clr) begin
			count_q <= '0;
		end else if (ctl.ins) begin
			count_q <= count_q + CW'(1);
		end else if (ctl.del || (cmd.pop && count_q != '0)) begin
			count_q <= count_q - CW'(1);
		end
	end

	assign count = count_q;
	assign head = lvl[0];

endmodule

/* rtl/price_level_book_update_top.sv */
// Price level book update: bid and ask sides kept sorted in chains of cells.
// Sequencing: busy is high while an accepted item is in the update state, so a new
// item is not taken until the last one is through. An item with the last mark then
// passes through the check state, the drop state when both sides hold levels
// (removing crossed levels) and the report state, after which done is raised.
// Reset clears both level counts and the overflow flag; stored levels are undefined.
module price_level_book_update_top #(
	parameter int LEVELS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  plbu_pkg::item_t   item,
	output logic              done,
	output plbu_pkg::result_t result
);

	localparam int CW = $clog2(LEVELS + 1);
	localparam int XW = (CW > plbu_pkg::LEVEL_CNT_BITS) ? CW : plbu_pkg::LEVEL_CNT_BITS;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_UPD  = 5'b00010,
		ST_CHK  = 5'b00100,
		ST_DROP = 5'b01000,
		ST_RPT  = 5'b10000
	} state_t;

	state_t state_q;
	plbu_pkg::item_t req_q;
	plbu_pkg::price_t best_bid_q;
	plbu_pkg::price_t best_ask_q;
	logic ovf_q;
	logic done_q;
	plbu_pkg::result_t result_q;

	plbu_pkg::row_cmd_t bid_cmd;
	plbu_pkg::row_cmd_t ask_cmd;
	logic [CW-1:0] bid_n;
	logic [CW-1:0] ask_n;
	plbu_pkg::level_t bid_head;
	plbu_pkg::level_t ask_head;
	logic bid_ovf;
	logic ask_ovf;
	logic accept;
	logic bid_pop;
	logic ask_pop;
	logic both_sides;
	logic [XW-1:0] bid_n_x;
	logic [XW-1:0] ask_n_x;

	assign accept = start && (state_q == ST_IDLE);
	assign busy = state_q != ST_IDLE;
	assign both_sides = (bid_n != '0) && (ask_n != '0);
	assign bid_pop = (state_q == ST_DROP) && (bid_n != '0) && (bid_head.price >= best_ask_q);
	assign ask_pop = (state_q == ST_DROP) && (ask_n != '0) && (ask_head.price <= best_bid_q);
	assign bid_n_x = XW'(bid_n);
	assign ask_n_x = XW'(ask_n);

	always_comb begin
		bid_cmd.cmp = accept;
		bid_cmd.clr = accept && item.first_of_message && item.snapshot;
		bid_cmd.upd = (state_q == ST_UPD) && req_q.level_present &&
			(req_q.side == plbu_pkg::SIDE_BID);
		bid_cmd.pop = bid_pop;
		if (state_q == ST_IDLE) begin
			bid_cmd.lvl.price = item.price;
			bid_cmd.lvl.volume = item.volume;
		end else begin
			bid_cmd.lvl.price = req_q.price;
			bid_cmd.lvl.volume = req_q.volume;
		end
		ask_cmd = bid_cmd;
		ask_cmd.upd = (state_q == ST_UPD) && req_q.level_present &&
			(req_q.side == plbu_pkg::SIDE_ASK);
		ask_cmd.pop = ask_pop;
	end

	plbu_row #(
		.LEVELS(LEVELS),
		.DESC  (1'b1),
		.CW    (CW)
	) u_bid (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (bid_cmd),
		.count   (bid_n),
		.head    (bid_head),
		.overflow(bid_ovf)
	);

	plbu_row #(
		.LEVELS(LEVELS),
		.DESC  (1'b0),
		.CW    (CW)
	) u_ask (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (ask_cmd),
		.count   (ask_n),
		.head    (ask_head),
		.overflow(ask_ovf)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ovf_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_UPD;
						if (item.first_of_message) begin
							ovf_q <= 1'b0;
						end
					end
				end
				ST_UPD: begin
					if (bid_ovf || ask_ovf) begin
						ovf_q <= 1'b1;
					end
					state_q <= req_q.last_of_message ? ST_CHK : ST_IDLE;
				end
				ST_CHK: begin
					state_q <= both_sides ? ST_DROP : ST_RPT;
				end
				ST_DROP: begin
					if (!bid_pop && !ask_pop) begin
						state_q <= ST_RPT;
					end
				end
				ST_RPT: begin
					done_q <= 1'b1;
					ovf_q <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= item;
		end
		if (state_q == ST_CHK) begin
			best_bid_q <= bid_head.price;
			best_ask_q <= ask_head.price;
		end
		if (state_q == ST_RPT) begin
			result_q.book_valid <= both_sides;
			result_q.best_bid_price <= (bid_n != '0) ? bid_head.price : '0;
			result_q.best_bid_volume <= (bid_n != '0) ? bid_head.volume : '0;
			result_q.best_ask_price <= (ask_n != '0) ? ask_head.price : '0;
			result_q.best_ask_volume <= (ask_n != '0) ? ask_head.volume : '0;
			result_q.bid_levels <= bid_n_x[plbu_pkg::LEVEL_CNT_BITS-1:0];
			result_q.ask_levels <= ask_n_x[plbu_pkg::LEVEL_CNT_BITS-1:0];
			result_q.overflow <= ovf_q;
		end
	end

	assign done = done_q;
	assign result = result_q;

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state is not one-hot");

	a_done_after_report: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_RPT))
		else $error("result strobe without a report cycle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(bid_n <= CW'(LEVELS)) && (ask_n <= CW'(LEVELS)))
		else $error("level count beyond capacity");

	a_uncrossed: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.book_valid |-> result.best_bid_price < result.best_ask_price)
		else $error("reported book is crossed");

endmodule

/* verif/price_level_book_checker.sv */
`timescale 1ns / 100ps
// Checker for the price level book update block: keeps its own copy of both book sides,
// predicts the report of every request that ends a message and compares each result.
// Depends on plbu_pkg only.
module price_level_book_checker #(
	parameter int LEVELS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  plbu_pkg::item_t   item,
	input  logic              done,
	input  plbu_pkg::result_t result,
	output int                fail_count,
	output int                pending
);

	plbu_pkg::price_t  level_px [2][LEVELS];
	plbu_pkg::volume_t level_vol [2][LEVELS];
	int                level_cnt [2];
	logic              level_dropped;
	plbu_pkg::result_t expected_reports [$];

	function automatic void remove_levels(int s, int idx, int k);
		for (int j = idx; j + k < level_cnt[s]; j++) begin
			level_px[s][j] = level_px[s][j + k];
			level_vol[s][j] = level_vol[s][j + k];
		end
		level_cnt[s] -= k;
	endfunction

	function automatic void put_level(int s, plbu_pkg::price_t p, plbu_pkg::volume_t v);
		int i;
		int pos;
		i = 0;
		while (i < level_cnt[s] && level_px[s][i] != p) i++;
		if (v == '0) begin
			if (i < level_cnt[s]) remove_levels(s, i, 1);
		end else if (i < level_cnt[s]) begin
			level_vol[s][i] = v;
		end else if (level_cnt[s] >= LEVELS) begin
			level_dropped = 1'b1;
		end else begin
			pos = 0;
			while (pos < level_cnt[s] &&
					(s == plbu_pkg::SIDE_BID ? level_px[s][pos] > p : level_px[s][pos] < p))
				pos++;
			for (int j = level_cnt[s]; j > pos; j--) begin
				level_px[s][j] = level_px[s][j - 1];
				level_vol[s][j] = level_vol[s][j - 1];
			end
			level_px[s][pos] = p;
			level_vol[s][pos] = v;
			level_cnt[s]++;
		end
	endfunction

	function automatic void update_book(plbu_pkg::item_t it);
		plbu_pkg::price_t  top_bid;
		plbu_pkg::price_t  top_ask;
		int                k;
		plbu_pkg::result_t rep;
		if (it.first_of_message) begin
			level_dropped = 1'b0;
			if (it.snapshot) begin
				level_cnt[plbu_pkg::SIDE_BID] = 0;
				level_cnt[plbu_pkg::SIDE_ASK] = 0;
			end
		end
		if (it.level_present) put_level(it.side, it.price, it.volume);
		if (!it.last_of_message) return;
		if (level_cnt[plbu_pkg::SIDE_BID] > 0 && level_cnt[plbu_pkg::SIDE_ASK] > 0) begin
			top_ask = level_px[plbu_pkg::SIDE_ASK][0];
			top_bid = level_px[plbu_pkg::SIDE_BID][0];
			k = 0;
			while (k < level_cnt[plbu_pkg::SIDE_BID] &&
					level_px[plbu_pkg::SIDE_BID][k] >= top_ask) k++;
			remove_levels(plbu_pkg::SIDE_BID, 0, k);
			k = 0;
			while (k < level_cnt[plbu_pkg::SIDE_ASK] &&
					level_px[plbu_pkg::SIDE_ASK][k] <= top_bid) k++;
			remove_levels(plbu_pkg::SIDE_ASK, 0, k);
		end
		rep = '0;
		rep.book_valid = level_cnt[plbu_pkg::SIDE_BID] > 0 &&
			level_cnt[plbu_pkg::SIDE_ASK] > 0;
		if (level_cnt[plbu_pkg::SIDE_BID] > 0) begin
			rep.best_bid_price = level_px[plbu_pkg::SIDE_BID][0];
			rep.best_bid_volume = level_vol[plbu_pkg::SIDE_BID][0];
		end
		if (level_cnt[plbu_pkg::SIDE_ASK] > 0) begin
			rep.best_ask_price = level_px[plbu_pkg::SIDE_ASK][0];
			rep.best_ask_volume = level_vol[plbu_pkg::SIDE_ASK][0];
		end
		rep.bid_levels = plbu_pkg::level_cnt_t'(level_cnt[plbu_pkg::SIDE_BID]);
		rep.ask_levels = plbu_pkg::level_cnt_t'(level_cnt[plbu_pkg::SIDE_ASK]);
		rep.overflow = level_dropped;
		level_dropped = 1'b0;
		expected_reports.push_back(rep);
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		plbu_pkg::result_t want;
		if (!arst_n) begin
			level_cnt[plbu_pkg::SIDE_BID] = 0;
			level_cnt[plbu_pkg::SIDE_ASK] = 0;
			level_dropped = 1'b0;
			expected_reports.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (done) begin
				if (expected_reports.size() == 0) begin
					$error("result reported with no request awaiting one");
					fail_count++;
				end else begin
					want = expected_reports.pop_front();
					check_field("book_valid", want.book_valid, result.book_valid);
					check_field("best_bid_price", want.best_bid_price, result.best_bid_price);
					check_field("best_bid_volume", want.best_bid_volume, result.best_bid_volume);
					check_field("best_ask_price", want.best_ask_price, result.best_ask_price);
					check_field("best_ask_volume", want.best_ask_volume, result.best_ask_volume);
					check_field("bid_levels", want.bid_levels, result.bid_levels);
					check_field("ask_levels", want.ask_levels, result.ask_levels);
					check_field("overflow", want.overflow, result.overflow);
				end
			end
			if (start && !busy) update_book(item);
			pending = expected_reports.size();
		end
	end

endmodule

/* verif/price_level_book_update_top_test.sv */
`timescale 1ns / 100ps
// Testbench top for the price level book update block: sends directed and random
// messages of price level requests and gives the verdict. Depends on plbu_pkg,
// price_level_book_update_top and price_level_book_checker.
module price_level_book_update_top_test;

	localparam int LEVELS = 64;
	localparam int TAIL_CYCLES = 80;
	localparam plbu_pkg::price_t PRICE_MAX = '1;
	localparam plbu_pkg::volume_t VOL_MAX = '1;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	plbu_pkg::item_t   item = '0;
	logic              busy;
	logic              done;
	plbu_pkg::result_t result;
	int                fail_count;
	int                pending;
	int                idle_pct = 0;
	int                sent = 0;
	plbu_pkg::price_t  mid_px = 32'd1000;

	price_level_book_update_top #(.LEVELS(LEVELS)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.item(item), .done(done), .result(result)
	);

	price_level_book_checker #(.LEVELS(LEVELS)) book_check (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .fail_count(fail_count), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	task automatic send_request(logic present, logic s, logic snap, logic first, logic last,
			plbu_pkg::price_t p, plbu_pkg::volume_t v);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item <= '{present, s, snap, first, last, p, v};
		do @(negedge clk); while (busy);
		@(posedge clk);
		if (present || first || last) sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	function automatic plbu_pkg::volume_t pick_volume();
		int r;
		r = $urandom_range(99);
		if (r < 18) return '0;
		if (r < 24) return VOL_MAX;
		if (r < 34) return plbu_pkg::volume_t'($urandom_range(1, 9));
		return plbu_pkg::volume_t'({$urandom, $urandom});
	endfunction

	// Most prices sit close to the mid so that levels get hit again; a few land
	// on the wrong side of it and cross the book.
	function automatic plbu_pkg::price_t pick_price(logic s);
		int unsigned off;
		off = $urandom_range(11);
		if ($urandom_range(9) == 0)
			return (s == plbu_pkg::SIDE_BID) ? mid_px + off : mid_px - off;
		return (s == plbu_pkg::SIDE_BID) ? mid_px - 1 - off : mid_px + 1 + off;
	endfunction

	task automatic send_message(int n, logic snap);
		logic s;
		for (int j = 0; j < n; j++) begin
			s = 1'($urandom_range(1));
			send_request($urandom_range(19) != 0, s, snap, j == 0, j == n - 1,
				pick_price(s), pick_volume());
		end
	endtask

	// A snapshot that offers more distinct prices than one side can hold.
	task automatic fill_side();
		logic s;
		int   n;
		int   off;
		s = 1'($urandom_range(1));
		n = $urandom_range(LEVELS + 2, LEVELS + 8);
		send_request(1'b1, !s, 1'b1, 1'b1, 1'b0,
			(s == plbu_pkg::SIDE_BID) ? mid_px + 200 : mid_px - 200,
			plbu_pkg::volume_t'($urandom_range(1, 1000)));
		for (int j = 0; j < n; j++) begin
			off = (j * 37) % n;
			send_request(1'b1, s, 1'b1, 1'b0, 1'b0,
				(s == plbu_pkg::SIDE_BID) ? mid_px - 1 - off : mid_px + 1 + off,
				plbu_pkg::volume_t'($urandom_range(1, 1000)));
		end
		send_request(1'b0, s, 1'b1, 1'b0, 1'b1, '0, '0);
	endtask

	task automatic run_phase(int pct, int target);
		int r;
		idle_pct = pct;
		sent = 0;
		while (sent < target) begin
			r = $urandom_range(99);
			if (r < 2) begin
				fill_side();
			end else if (r < 12) begin
				send_request(1'($urandom_range(1)), 1'($urandom_range(1)),
					1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
					$urandom, plbu_pkg::volume_t'({$urandom, $urandom}));
			end else begin
				if (r < 15) mid_px = $urandom_range(1) ? 32'd6 : PRICE_MAX - 6;
				else if (r < 30) mid_px = $urandom;
				send_message($urandom_range(1, 8), r < 30);
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_pct = 6;
		send_request(1'b0, plbu_pkg::SIDE_BID, 1'b0, 1'b1, 1'b1, '0, '0);
		send_request(1'b1, plbu_pkg::SIDE_BID, 1'b1, 1'b1, 1'b0, 32'd100, VOL_MAX);
		send_request(1'b1, plbu_pkg::SIDE_BID, 1'b1, 1'b0, 1'b0, '0, 48'd1);
		send_request(1'b1, plbu_pkg::SIDE_ASK, 1'b1, 1'b0, 1'b0, 32'd200, 48'd5);
		send_request(1'b1, plbu_pkg::SIDE_ASK, 1'b1, 1'b0, 1'b0, PRICE_MAX, VOL_MAX);
		send_request(1'b1, plbu_pkg::SIDE_ASK, 1'b1, 1'b0, 1'b1, 32'd150, 48'd7);
		send_request(1'b1, plbu_pkg::SIDE_BID, 1'b0, 1'b1, 1'b0, 32'd100, 48'd3);
		send_request(1'b1, plbu_pkg::SIDE_BID, 1'b0, 1'b0, 1'b0, 32'd555, '0);
		send_request(1'b1, plbu_pkg::SIDE_ASK, 1'b0, 1'b0, 1'b0, 32'd200, '0);
		send_request(1'b1, plbu_pkg::SIDE_BID, 1'b0, 1'b0, 1'b1, 32'd120, 48'd9);
		send_request(1'b1, plbu_pkg::SIDE_BID, 1'b0, 1'b1, 1'b0, 32'd160, 48'd4);
		send_request(1'b1, plbu_pkg::SIDE_ASK, 1'b0, 1'b0, 1'b1, 32'd90, 48'd6);
		send_request(1'b0, plbu_pkg::SIDE_ASK, 1'b1, 1'b1, 1'b0, '0, '0);
		send_request(1'b1, plbu_pkg::SIDE_BID, 1'b1, 1'b0, 1'b1, 32'd10, 48'd1);
		send_request(1'b1, plbu_pkg::SIDE_ASK, 1'b0, 1'b0, 1'b1, 32'd20, 48'd2);
		send_request(1'b1, plbu_pkg::SIDE_ASK, 1'b1, 1'b1, 1'b1, 32'd5, 48'd5);
		send_request(1'b1, plbu_pkg::SIDE_BID, 1'b0, 1'b1, 1'b1, PRICE_MAX, 48'd8);
		drain();
		run_phase(6, 580);
		drain();
		run_phase(61, 580);
		drain();
		run_phase(0, 580);
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
